[hdl/hrsp_pkg.sv]
`timescale 1ns / 1ps

package hrsp_pkg;

  // Field widths of the channel words and of the per-way state.
  localparam int WAY_W  = 4;
  localparam int AGE_W  = 3;
  localparam int RRPV_W = 3;

  // Default number of ways in the set.
  localparam int WAYS_DEFAULT = 16;

  // Re-reference values with a fixed meaning.
  localparam logic [RRPV_W-1:0] RRPV_MAX       = 3'd7;
  localparam logic [RRPV_W-1:0] RRPV_FRIENDLY  = 3'd0;
  localparam logic [RRPV_W-1:0] RRPV_AGE_LIMIT = 3'd6;

  // Number of distinct re-reference values.
  localparam int RRPV_LEVELS = 1 << RRPV_W;

  // The victim search looks at the ways in groups of this size.
  localparam int GRP_W = 3;
  localparam int GRP   = 1 << GRP_W;

  // Command codes carried in the cmd field.
  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_VICTIM = 1'b1;

  // Steps that the controller asks of the datapath.
  typedef struct packed {
    logic upd;   // apply an access word taken this cycle
    logic max;   // note which values are present in the set
    logic age;   // raise every way by the ageing amount
    logic find;  // look for ways at the maximum in every group
    logic emit;  // load the result register
  } ctl_cmd_t;

  // What the datapath reports back.
  typedef struct packed {
    logic out_free;  // the result register can take a new word
  } ctl_sts_t;

endpackage

[hdl/hrsp_if.sv]
`timescale 1ns / 1ps

// Request channel: one access or victim request per word.
interface hrsp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [hrsp_pkg::WAY_W-1:0] way;
  logic                       averse;
  logic                       hit;

  modport source (output valid, output cmd, output way, output averse, output hit,
                  input ready);
  modport sink   (input valid, input cmd, input way, input averse, input hit,
                  output ready);
endinterface

// Result channel: one word per victim request.
interface hrsp_out_if;
  logic                       valid;
  logic                       ready;
  logic [hrsp_pkg::WAY_W-1:0] victim_way;
  logic [hrsp_pkg::AGE_W-1:0] aged_by;

  modport source (output valid, output victim_way, output aged_by, input ready);
  modport sink   (input valid, input victim_way, input aged_by, output ready);
endinterface

[hdl/hawkeye_rrpv_set_policy_unit.sv]
`timescale 1ns / 1ps

// RRIP replacement state for one cache set, three bits per way, with a request
// channel and a result channel. An access word is taken and applied at the
// clock edge on which it is accepted, so accesses can stream at one per clock
// while no victim search runs. A victim request closes the request channel
// until the next free slot: the controller walks through finding which values
// are present, ageing every way, searching the ways in groups of eight for the
// maximum, and loading the result register. The result register decouples the
// two sides, so access words are taken while a result waits; a second victim
// request holds in its last step until the previous result has been taken.
// There is no clearing pass: all ways read zero straight out of reset.
module hawkeye_rrpv_set_policy_unit #(
  parameter int WAYS = hrsp_pkg::WAYS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  hrsp_in_if.sink           in_ch,
  hrsp_out_if.source        out_ch
);
  import hrsp_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequencer for the victim search.
  hrsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Way values, search registers and result register.
  hrsp_datapath #(
    .WAYS (WAYS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_way         (in_ch.way),
    .in_averse      (in_ch.averse),
    .in_hit         (in_ch.hit),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_victim_way (out_ch.victim_way),
    .out_aged_by    (out_ch.aged_by)
  );

`ifndef SYNTHESIS
  // A victim request closes the request channel for the following cycle.
  a_victim_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_VICTIM) |=> !in_ch.ready)
    else $error("request channel open right after a victim request");

  // An access word never holds up the next one.
  a_access_streams: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_ACCESS) |=> in_ch.ready)
    else $error("request channel closed after an access word");

  // The result register is loaded only when it is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten before it was taken");

  // A new result appears as the search ends and the request channel reopens.
  a_result_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> in_ch.ready)
    else $error("result shown while the search is still running");
`endif

endmodule

[hdl/hrsp_ctrl.sv]
`timescale 1ns / 1ps

module hrsp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_ready,
  input  hrsp_pkg::ctl_sts_t sts,
  output hrsp_pkg::ctl_cmd_t cmd
);
  import hrsp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAX,
    S_AGE,
    S_FIND,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   take;

  assign take     = in_valid && in_ready_r;
  assign in_ready = in_ready_r;

  // Sequence of a victim search; access words are handled in the idle state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (take && in_cmd == CMD_VICTIM) begin
            state_r    <= S_MAX;
            in_ready_r <= 1'b0;
          end
        end
        S_MAX:  state_r <= S_AGE;
        S_AGE:  state_r <= S_FIND;
        S_FIND: state_r <= S_EMIT;
        S_EMIT: begin
          if (sts.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  // Decode the state into datapath steps.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  cmd.upd  = take && in_cmd == CMD_ACCESS;
      S_MAX:   cmd.max  = 1'b1;
      S_AGE:   cmd.age  = 1'b1;
      S_FIND:  cmd.find = 1'b1;
      S_EMIT:  cmd.emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[hdl/hrsp_datapath.sv]
`timescale 1ns / 1ps

module hrsp_datapath #(
  parameter int WAYS = hrsp_pkg::WAYS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hrsp_pkg::ctl_cmd_t         cmd,
  output hrsp_pkg::ctl_sts_t         sts,
  input  logic [hrsp_pkg::WAY_W-1:0] in_way,
  input  logic                       in_averse,
  input  logic                       in_hit,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hrsp_pkg::WAY_W-1:0] out_victim_way,
  output logic [hrsp_pkg::AGE_W-1:0] out_aged_by
);
  import hrsp_pkg::*;

  localparam int NGRP = (WAYS + GRP - 1) / GRP;
  localparam int IW   = ($clog2(WAYS) > WAY_W) ? $clog2(WAYS) : WAY_W;

  logic [RRPV_W-1:0]      rrpv_r   [WAYS];
  logic [RRPV_W-1:0]      rrpv_nxt [WAYS];
  logic [RRPV_LEVELS-1:0] pres_r;
  logic [RRPV_LEVELS-1:0] pres_nxt;
  logic [AGE_W-1:0]       age_r;
  logic [AGE_W-1:0]       age_nxt;
  logic [NGRP-1:0]        grp_any_r;
  logic [NGRP-1:0]        grp_any_nxt;
  logic [GRP_W-1:0]       grp_low_r   [NGRP];
  logic [GRP_W-1:0]       grp_low_nxt [NGRP];
  logic [IW-1:0]          vidx;
  logic                   out_valid_r;
  logic [WAY_W-1:0]       victim_way_r;
  logic [AGE_W-1:0]       aged_by_r;
  logic                   way_ok;

  assign way_ok = 32'(in_way) < WAYS;

  // Ageing amount: seven minus the largest value present in the set.
  always_comb begin
    logic [RRPV_W-1:0] maxv;
    maxv = RRPV_FRIENDLY;
    for (int v = 0; v < RRPV_LEVELS; v++) begin
      if (pres_r[v]) begin
        maxv = RRPV_W'(v);
      end
    end
    age_nxt = AGE_W'(RRPV_MAX - maxv);
  end

  // Per-way update for an access word or for the ageing step.
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rrpv_nxt[i] = rrpv_r[i];
      if (cmd.upd && way_ok) begin
        if (32'(in_way) == i) begin
          rrpv_nxt[i] = in_averse ? RRPV_MAX : RRPV_FRIENDLY;
        end else if (!in_averse && !in_hit && rrpv_r[i] < RRPV_AGE_LIMIT) begin
          rrpv_nxt[i] = rrpv_r[i] + 1'b1;
        end
      end else if (cmd.age) begin
        rrpv_nxt[i] = rrpv_r[i] + RRPV_W'(age_nxt);
      end
    end
  end

  // Which values occur anywhere in the set.
  always_comb begin
    pres_nxt = '0;
    for (int i = 0; i < WAYS; i++) begin
      pres_nxt[rrpv_r[i]] = 1'b1;
    end
  end

  // Lowest way at the maximum within each group of ways.
  always_comb begin
    int idx;
    for (int g = 0; g < NGRP; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_low_nxt[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        idx = g * GRP + j;
        if (idx < WAYS) begin
          if (rrpv_r[idx] == RRPV_MAX) begin
            grp_any_nxt[g] = 1'b1;
            grp_low_nxt[g] = GRP_W'(j);
          end
        end
      end
    end
  end

  // The lowest group with a hit gives the victim.
  always_comb begin
    vidx = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        vidx = IW'(g * GRP) + IW'(grp_low_r[g]);
      end
    end
  end

  // Way values and the result flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WAYS; i++) begin
        rrpv_r[i] <= RRPV_FRIENDLY;
      end
      out_valid_r <= 1'b0;
    end else begin
      rrpv_r <= rrpv_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Intermediate results of the victim search and the result word.
  always_ff @(posedge clk) begin
    if (cmd.max) begin
      pres_r <= pres_nxt;
    end
    if (cmd.age) begin
      age_r <= age_nxt;
    end
    if (cmd.find) begin
      grp_any_r <= grp_any_nxt;
      grp_low_r <= grp_low_nxt;
    end
    if (cmd.emit) begin
      victim_way_r <= vidx[WAY_W-1:0];
      aged_by_r    <= age_r;
    end
  end

  assign sts.out_free    = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_victim_way  = victim_way_r;
  assign out_aged_by     = aged_by_r;

endmodule
